>>> rtl/fbd_pkg.sv
// Package for the forgiving base64 decoder.
// Holds the character classes, queue records, register map and alphabet lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbd_pkg;

    localparam int CHAR_W      = 8;
    localparam int SEXTET_W    = 6;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 2;
    localparam int MID_DEPTH_D = 2;
    localparam int OUT_DEPTH_D = 2;

    localparam logic [ADDR_W-1:0] REG_URL_ALPHABET = 2'd0;

    localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        CLS_BLANK = 2'd0,
        CLS_PAD   = 2'd1,
        CLS_DATA  = 2'd2,
        CLS_BAD   = 2'd3
    } char_class_t;

    typedef struct packed {
        char_class_t          cls;
        logic [SEXTET_W-1:0]  sextet;
        logic                 last;
    } class_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] byte_out;
        logic              byte_valid;
        logic              done_res;
        logic              decode_error;
    } result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    localparam int CLASS_ITEM_W = $bits(class_item_t);
    localparam int RESULT_W     = $bits(result_t);

    // Map one character to its class and sextet value.
    function automatic class_item_t classify(input logic [CHAR_W-1:0] c, input logic url,
                                             input logic last);
        class_item_t r;
        r.cls    = CLS_BAD;
        r.sextet = '0;
        r.last   = last;
        if (c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR || c == CH_SPACE) begin
            r.cls = CLS_BLANK;
        end else if (c == CH_PAD) begin
            r.cls = CLS_PAD;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.cls    = CLS_DATA;
            r.sextet = SEXTET_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.cls    = CLS_DATA;
            r.sextet = SEXTET_W'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.cls    = CLS_DATA;
            r.sextet = SEXTET_W'(c - 8'h30 + 8'd52);
        end else if ((!url && c == 8'h2B) || (url && c == 8'h2D)) begin
            r.cls    = CLS_DATA;
            r.sextet = 6'd62;
        end else if ((!url && c == 8'h2F) || (url && c == 8'h5F)) begin
            r.cls    = CLS_DATA;
            r.sextet = 6'd63;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fbd_fifo.sv
// Small first-in first-out queue built from flip-flops.
// Used between front and back, and as the result queue. Depends on fbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    output logic [WIDTH-1:0]          rd_data,
    output fbd_pkg::queue_status_t    status
);
    import fbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == DEPTH_C);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a write");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (status.empty || status.full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/fbd_front.sv
// Front part: configuration register and character classification.
// Feeds classified characters into the middle queue. Depends on fbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fbd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [fbd_pkg::DATA_W-1:0]    pwdata,
    output logic [fbd_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  wire logic [fbd_pkg::CHAR_W-1:0]    char_in,
    input  wire logic                          end_of_text,
    output fbd_pkg::class_item_t               item
);
    import fbd_pkg::*;

    logic url_alphabet_reg, url_alphabet_next;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        url_alphabet_next = url_alphabet_reg;
        if (cfg_wr && paddr == REG_URL_ALPHABET)
        begin
            url_alphabet_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_alphabet_reg <= 1'b0;
        end else
        begin
            url_alphabet_reg <= url_alphabet_next;
        end
    end

    assign prdata = (paddr == REG_URL_ALPHABET) ? {{(DATA_W-1){1'b0}}, url_alphabet_reg} : '0;
    assign item   = classify(char_in, url_alphabet_reg, end_of_text);

endmodule

`default_nettype wire

>>> rtl/fbd_back.sv
// Back part: group position, pending bits and padding state; builds result records.
// Reads classified characters from the middle queue. Depends on fbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbd_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire fbd_pkg::class_item_t    item,
    input  wire fbd_pkg::queue_status_t  mid_status,
    input  wire fbd_pkg::queue_status_t  out_status,
    output logic                         item_pop,
    output logic                         res_push,
    output fbd_pkg::result_t             res
);
    import fbd_pkg::*;

    logic [1:0]          group_reg, group_next;
    logic [SEXTET_W-1:0] pend_reg, pend_next;
    logic [1:0]          pad_reg, pad_next;
    logic                err_reg, err_next;
    logic                fire;
    logic                have_byte;
    logic [CHAR_W-1:0]   byte_val;
    logic                end_err;

    assign fire     = !mid_status.empty && !out_status.full;
    assign item_pop = fire;

    always_comb
    begin
        group_next = group_reg;
        pend_next  = pend_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        have_byte  = 1'b0;
        byte_val   = '0;
        unique case (item.cls)
            CLS_BLANK:
            begin
            end
            CLS_PAD:
            begin
                if (pad_reg != 2'd3)
                begin
                    pad_next = pad_reg + 2'd1;
                end
            end
            CLS_DATA:
            begin
                if (pad_reg != 2'd0)
                begin
                    err_next = 1'b1;
                end else
                begin
                    case (group_reg)
                        2'd0:
                        begin
                            pend_next = item.sextet;
                        end
                        2'd1:
                        begin
                            byte_val  = {pend_reg, item.sextet[5:4]};
                            pend_next = {2'b00, item.sextet[3:0]};
                            have_byte = 1'b1;
                        end
                        2'd2:
                        begin
                            byte_val  = {pend_reg[3:0], item.sextet[5:2]};
                            pend_next = {4'b0000, item.sextet[1:0]};
                            have_byte = 1'b1;
                        end
                        default:
                        begin
                            byte_val  = {pend_reg[1:0], item.sextet};
                            pend_next = '0;
                            have_byte = 1'b1;
                        end
                    endcase
                    group_next = group_reg + 2'd1;
                    // drop bytes once the text is known bad
                    if (err_reg)
                    begin
                        have_byte = 1'b0;
                    end
                end
            end
            default:
            begin
                err_next = 1'b1;
            end
        endcase

        end_err = err_next
               || (pad_next == 2'd0 && group_next == 2'd1)
               || (pad_next == 2'd1 && group_next != 2'd3)
               || (pad_next == 2'd2 && group_next != 2'd2)
               || (pad_next == 2'd3);

        res.byte_out     = have_byte ? byte_val : '0;
        res.byte_valid   = have_byte;
        res.done_res     = item.last;
        res.decode_error = item.last && end_err;

        if (item.last)
        begin
            group_next = '0;
            pend_next  = '0;
            pad_next   = '0;
            err_next   = 1'b0;
        end
    end

    assign res_push = fire && (have_byte || item.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
            pend_reg  <= '0;
            pad_reg   <= '0;
            err_reg   <= 1'b0;
        end else if (fire)
        begin
            group_reg <= group_next;
            pend_reg  <= pend_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
        end
    end

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.last) |=> (group_reg == 2'd0 && pad_reg == 2'd0 && !err_reg))
        else $error("text state not cleared after final character");

    a_no_byte_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && err_reg) |-> !res.byte_valid)
        else $error("byte emitted after error");

    a_pad_blocks_data: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pad_reg != 2'd0 && !item.last) |=> $stable(group_reg))
        else $error("group advanced after padding");

endmodule

`default_nettype wire

>>> rtl/forgiving_base64_decoder_unit.sv
// Top level of the forgiving base64 decoder: front, middle queue, back, result queue.
// Depends on fbd_pkg, fbd_front, fbd_fifo and fbd_back.
//
// Usage:
//   Characters enter on the push/full side, one per transfer: char_in plus end_of_text
//   on the final character of a text. Whitespace is skipped, '=' counts as padding.
//   Results leave on the empty/pop side. A result carries a decoded byte (byte_valid),
//   the end-of-text mark (done_res) with the sticky decode_error, or both.
//   Bytes stream out as they complete; on decode_error the consumer drops the text.
//   url_alphabet at byte address 0 of the APB port picks the '-' '_' alphabet; write
//   it only while the block is idle.
// Timing:
//   One character per clock sustained while the receiver keeps popping. A result is
//   visible on the result ports after passing through a two-entry middle queue and a
//   two-entry result queue, each a single register stage.
//   When the receiver stops popping, the result queue fills, the back part holds and
//   the middle queue fills, then full rises; nothing is lost.
// Reset:
//   rst_n clears both queues, the text state and url_alphabet; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module forgiving_base64_decoder_unit #(
    parameter int MID_DEPTH = fbd_pkg::MID_DEPTH_D,
    parameter int OUT_DEPTH = fbd_pkg::OUT_DEPTH_D
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fbd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [fbd_pkg::DATA_W-1:0]    pwdata,
    output logic [fbd_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [fbd_pkg::CHAR_W-1:0]    char_in,
    input  wire logic                          end_of_text,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [fbd_pkg::CHAR_W-1:0]         byte_out,
    output logic                               byte_valid,
    output logic                               done_res,
    output logic                               decode_error
);
    import fbd_pkg::*;

    class_item_t   front_item;
    class_item_t   mid_item;
    logic [CLASS_ITEM_W-1:0] mid_rd_bits;
    queue_status_t mid_status;
    queue_status_t out_status;
    logic          item_pop;
    logic          res_push;
    result_t       back_res;
    result_t       out_res;
    logic [RESULT_W-1:0] out_rd_bits;

    fbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .item        (front_item)
    );

    fbd_fifo #(
        .WIDTH (CLASS_ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .rd_en   (item_pop),
        .rd_data (mid_rd_bits),
        .status  (mid_status)
    );

    assign mid_item = class_item_t'(mid_rd_bits);
    assign full     = mid_status.full;

    fbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_item),
        .mid_status (mid_status),
        .out_status (out_status),
        .item_pop   (item_pop),
        .res_push   (res_push),
        .res        (back_res)
    );

    fbd_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (out_rd_bits),
        .status  (out_status)
    );

    assign out_res      = result_t'(out_rd_bits);
    assign empty        = out_status.empty;
    assign byte_out     = out_res.byte_out;
    assign byte_valid   = out_res.byte_valid;
    assign done_res     = out_res.done_res;
    assign decode_error = out_res.decode_error;

endmodule

`default_nettype wire
